FILE: rtl/sensor_command_frame_codec_defines.svh
// ---------------------------------------------------------------------------
// Sensor command frame codec: assertion macros
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef SENSOR_COMMAND_FRAME_CODEC_DEFINES_SVH
`define SENSOR_COMMAND_FRAME_CODEC_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SCFC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SCFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/scfc_pkg.sv
// ---------------------------------------------------------------------------
// Sensor command frame codec package
// Item modes, reply status codes and frame constants.
// ---------------------------------------------------------------------------
`default_nettype none

package scfc_pkg;

  localparam int unsigned FrameLen = 9;
  localparam int unsigned CntW     = 4;

  localparam logic [7:0] StartByte  = 8'hFF;
  localparam logic [7:0] SensorAddr = 8'h01;
  localparam logic [7:0] LongReadRst = 8'd133;

  localparam logic [CntW-1:0] LastIdx = CntW'(FrameLen - 1);

  typedef enum logic [1:0] {
    MODE_CMD     = 2'd0,
    MODE_RX      = 2'd1,
    MODE_TIMEOUT = 2'd2
  } scfc_mode_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_CSUM_BAD = 2'd2,
    STATUS_REJECTED = 2'd3
  } scfc_status_e;

  // Register byte-address word index of long_read_command.
  localparam logic REG_LONG_READ = 1'b0;

endpackage

`default_nettype wire

FILE: rtl/sensor_command_frame_codec.sv
// ---------------------------------------------------------------------------
// Sensor command frame codec
// Builds nine-byte command frames and checks nine-byte sensor replies.
// ---------------------------------------------------------------------------
//  Channel   Dir  Handshake             Payload
//  in        in   in_valid_i/in_stall_o mode, command_code, payload, rx_byte
//  out       out  out_valid_o/out_stall_i tx_*, reply_*, concentration
//  config    in   APB (psel/penable)    long_read_command at address 0
//
// A new received byte or timeout enters every cycle unless the output stalls.
// A command holds the stage register while its nine frame bytes are sent, one at a time.
// Items pass the input register, then the result register.
// Reset clears the receive count, the last command and the stage and output valid flags.
// The input stalls only while the stage holds an item that cannot leave.
// ---------------------------------------------------------------------------
`default_nettype none

`include "sensor_command_frame_codec_defines.svh"

module sensor_command_frame_codec
  import scfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  mode_i,
  input  wire logic [7:0]  command_code_i,
  input  wire logic [39:0] payload_i,
  input  wire logic [7:0]  rx_byte_i,
  // Output channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             tx_valid_o,
  output logic [7:0]       tx_byte_o,
  output logic             tx_last_o,
  output logic             reply_valid_o,
  output logic [1:0]       reply_status_o,
  output logic [31:0]      concentration_o,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Configuration
  logic [7:0] long_read_q;
  logic       reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == REG_LONG_READ);
  assign prdata  = reg_hit ? {24'd0, long_read_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_read_q <= LongReadRst;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      long_read_q <= pwdata[7:0];
    end
  end

  // Stage register
  logic            s1_valid_q;
  logic [1:0]      s1_mode_q;
  logic [7:0]      s1_cmd_q;
  logic [39:0]     s1_payload_q;
  logic [7:0]      s1_rx_q;
  logic [CntW-1:0] byte_idx_q;

  // Receive state
  logic [7:0]      reply_q [FrameLen-1];
  logic [CntW-1:0] count_q;
  logic [7:0]      pending_q;

  // Result register
  logic        out_valid_q;
  logic        tx_valid_q;
  logic [7:0]  tx_byte_q;
  logic        tx_last_q;
  logic        reply_valid_q;
  logic [1:0]  reply_status_q;
  logic [31:0] conc_q;

  logic            out_free;
  logic            rx_full;
  logic [CntW-1:0] count_eff;
  logic            needs_out;
  logic            s1_done;
  logic            fire;
  logic            in_accept;

  logic [7:0]  tx_csum;
  logic [7:0]  tx_sel;
  logic [7:0]  rx_sum;
  logic [7:0]  rx_csum;
  logic [1:0]  rx_status;
  logic [31:0] rx_conc;

  // A count of nine or more cannot arise, but is treated as an empty frame.
  assign count_eff = (count_q > LastIdx) ? '0 : count_q;
  assign rx_full   = (count_eff == LastIdx);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    case (s1_mode_q)
      MODE_CMD:     needs_out = 1'b1;
      MODE_RX:      needs_out = rx_full;
      MODE_TIMEOUT: needs_out = 1'b1;
      default:      needs_out = 1'b0;
    endcase
  end

  assign s1_done    = (s1_mode_q != MODE_CMD) || (byte_idx_q == LastIdx);
  assign fire       = s1_valid_q && (!needs_out || out_free);
  assign in_stall_o = s1_valid_q && !(fire && s1_done);
  assign in_accept  = in_valid_i && !in_stall_o;

  // Outgoing frame byte selected by the byte index.
  assign tx_csum = 8'h00 - (SensorAddr + s1_cmd_q + s1_payload_q[39:32] +
                   s1_payload_q[31:24] + s1_payload_q[23:16] +
                   s1_payload_q[15:8] + s1_payload_q[7:0]);

  always_comb begin
    case (byte_idx_q)
      4'd0:    tx_sel = StartByte;
      4'd1:    tx_sel = SensorAddr;
      4'd2:    tx_sel = s1_cmd_q;
      4'd3:    tx_sel = s1_payload_q[39:32];
      4'd4:    tx_sel = s1_payload_q[31:24];
      4'd5:    tx_sel = s1_payload_q[23:16];
      4'd6:    tx_sel = s1_payload_q[15:8];
      4'd7:    tx_sel = s1_payload_q[7:0];
      default: tx_sel = tx_csum;
    endcase
  end

  // Reply check: the incoming byte is the checksum, bytes 0..7 are stored.
  assign rx_sum  = reply_q[1] + reply_q[2] + reply_q[3] + reply_q[4] +
                   reply_q[5] + reply_q[6] + reply_q[7];
  assign rx_csum = 8'h00 - rx_sum;

  always_comb begin
    rx_conc = 32'd0;
    if (s1_rx_q != rx_csum) begin
      rx_status = STATUS_CSUM_BAD;
    end else if (reply_q[1] != pending_q) begin
      rx_status = STATUS_REJECTED;
    end else begin
      rx_status = STATUS_OK;
      if (pending_q == long_read_q) begin
        rx_conc = {reply_q[2], reply_q[3], reply_q[4], reply_q[5]};
      end else begin
        rx_conc = {16'd0, reply_q[2], reply_q[3]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byte_idx_q <= '0;
      count_q    <= '0;
      pending_q  <= 8'd0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (fire && s1_done) begin
        s1_valid_q <= 1'b0;
      end
      if (fire) begin
        case (s1_mode_q)
          MODE_CMD: begin
            byte_idx_q <= s1_done ? '0 : byte_idx_q + 1'b1;
            count_q    <= '0;
            pending_q  <= s1_cmd_q;
          end
          MODE_RX: begin
            count_q <= rx_full ? '0 : count_eff + 1'b1;
          end
          MODE_TIMEOUT: begin
            count_q <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q    <= mode_i;
      s1_cmd_q     <= command_code_i;
      s1_payload_q <= payload_i;
      s1_rx_q      <= rx_byte_i;
    end
    if (fire && (s1_mode_q == MODE_RX) && !rx_full) begin
      reply_q[count_eff[2:0]] <= s1_rx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire && needs_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && needs_out) begin
      if (s1_mode_q == MODE_CMD) begin
        tx_valid_q     <= 1'b1;
        tx_byte_q      <= tx_sel;
        tx_last_q      <= (byte_idx_q == LastIdx);
        reply_valid_q  <= 1'b0;
        reply_status_q <= STATUS_OK;
        conc_q         <= 32'd0;
      end else begin
        tx_valid_q    <= 1'b0;
        tx_byte_q     <= 8'd0;
        tx_last_q     <= 1'b0;
        reply_valid_q <= 1'b1;
        if (s1_mode_q == MODE_RX) begin
          reply_status_q <= rx_status;
          conc_q         <= rx_conc;
        end else begin
          reply_status_q <= STATUS_SHORT;
          conc_q         <= 32'd0;
        end
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign tx_valid_o      = tx_valid_q;
  assign tx_byte_o       = tx_byte_q;
  assign tx_last_o       = tx_last_q;
  assign reply_valid_o   = reply_valid_q;
  assign reply_status_o  = reply_status_q;
  assign concentration_o = conc_q;

  // Assertions
  `SCFC_ASSERT_NOW(a_one_result_kind, out_valid_q, tx_valid_q != reply_valid_q, "result is neither tx byte nor reply")
  `SCFC_ASSERT_NOW(a_count_range, 1'b1, count_q <= LastIdx, "receive count beyond frame length")
  `SCFC_ASSERT_NOW(a_conc_zero, out_valid_q && reply_valid_q && (reply_status_q != STATUS_OK), conc_q == 32'd0, "concentration set on failed reply")
  `SCFC_ASSERT_NEXT(a_pending_cmd, fire && s1_done && (s1_mode_q == MODE_CMD), pending_q == $past(s1_cmd_q), "sent command not remembered")

endmodule

`default_nettype wire
